// File: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared codes for the sorted priority queue
// Operation, status and cell command codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam logic [1:0] FN_INSERT   = 2'd0;
    localparam logic [1:0] FN_POP_HIGH = 2'd1;
    localparam logic [1:0] FN_POP_LOW  = 2'd2;
    localparam logic [1:0] FN_PEEK     = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int PRI_WIDTH = 32;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2
    } t_cell_op;

    // Broadcast to every cell in the chain
    typedef struct packed {
        t_cell_op                    op;
        logic signed [PRI_WIDTH-1:0] pri;
    } t_cell_ctl;

endpackage

// File: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one priority/data entry; compares against the broadcast priority and
// takes its own value, the new entry, or a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = 16,
    parameter int CW         = 7
) (
    input  logic                        i_clk,
    input  t_cell_ctl                   i_ctl,
    input  logic [DATA_WIDTH-1:0]       i_new_data,
    input  logic [CW-1:0]               i_count,
    input  logic                        i_prev_lt,
    input  logic signed [PRI_WIDTH-1:0] i_prev_pri,
    input  logic [DATA_WIDTH-1:0]       i_prev_data,
    input  logic signed [PRI_WIDTH-1:0] i_next_pri,
    input  logic [DATA_WIDTH-1:0]       i_next_data,
    output logic                        o_lt,
    output logic signed [PRI_WIDTH-1:0] o_pri,
    output logic [DATA_WIDTH-1:0]       o_data
);

    logic signed [PRI_WIDTH-1:0] r_pri, n_pri;
    logic [DATA_WIDTH-1:0]       r_data, n_data;
    logic                        w_occ;

    assign w_occ = CW'(IDX) < i_count;
    assign o_lt  = w_occ && (r_pri < i_ctl.pri);

    always_comb begin
        n_pri  = r_pri;
        n_data = r_data;
        case (i_ctl.op)
            CELL_INSERT: begin
                // strictly smaller entries stay; the new entry lands at the boundary
                if (!o_lt) begin
                    if (i_prev_lt) begin
                        n_pri  = i_ctl.pri;
                        n_data = i_new_data;
                    end else begin
                        n_pri  = i_prev_pri;
                        n_data = i_prev_data;
                    end
                end
            end
            CELL_SHIFT: begin
                n_pri  = i_next_pri;
                n_data = i_next_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pri  <= n_pri;
        r_data <= n_data;
    end

    assign o_pri  = r_pri;
    assign o_data = r_data;

endmodule

// File: sv/spq_tree.sv
// ----------------------------------------------------------------------------
// spq_tree: registered readout of one cell by index
// Two-level AND-OR select: groups of eight, then across groups.
// ----------------------------------------------------------------------------
module spq_tree #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 16,
    parameter int IW         = 6
) (
    input  logic                  i_clk,
    input  logic [DATA_WIDTH-1:0] i_data [CAPACITY],
    input  logic [IW-1:0]         i_idx,
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam int GS = 8;
    localparam int NG = (CAPACITY + GS - 1) / GS;

    logic [DATA_WIDTH-1:0] w_mask [NG*GS];
    logic [DATA_WIDTH-1:0] r_grp  [NG];
    logic [DATA_WIDTH-1:0] r_sel;
    logic [DATA_WIDTH-1:0] w_or;

    for (genvar k = 0; k < NG*GS; k++) begin : g_mask
        if (k < CAPACITY) begin : g_real
            assign w_mask[k] = (i_idx == IW'(k)) ? i_data[k] : '0;
        end else begin : g_pad
            assign w_mask[k] = '0;
        end
    end

    for (genvar g = 0; g < NG; g++) begin : g_grp
        logic [DATA_WIDTH-1:0] w_acc;
        always_comb begin
            w_acc = '0;
            for (int j = 0; j < GS; j++) begin
                w_acc = w_acc | w_mask[g*GS+j];
            end
        end
        always_ff @(posedge i_clk) begin
            r_grp[g] <= w_acc;
        end
    end

    always_comb begin
        w_or = '0;
        for (int g = 0; g < NG; g++) begin
            w_or = w_or | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel <= w_or;
    end

    assign o_data = r_sel;

endmodule

// File: sv/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top: fixed-capacity sorted priority queue
// Entries are kept in ascending priority order in a chain of cells.
// ----------------------------------------------------------------------------
// The result strobe is registered from the execute state, after RD1 and RD2.
// No new command is taken while busy; busy covers the two-stage registered
//   readout of the top cell and the execute state that updates the chain.
// Reset: clears the fill count, the sequencer and the strobe; cell contents
//   stay undefined and are never read before they are written.
// The receiver cannot stall: each result beat is shown for one cycle only.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_func,
    input  logic [DATA_WIDTH-1:0]       i_new_data,
    input  logic signed [PRI_WIDTH-1:0] i_new_priority,
    output logic                        o_strobe,
    output logic [DATA_WIDTH-1:0]       o_result_data,
    output logic                        o_result_valid,
    output logic [1:0]                  o_status,
    output logic [$clog2(CAPACITY+1)-1:0] o_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD1  = 2'd1;
    localparam logic [1:0] S_RD2  = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [1:0]                  r_func;
    logic [DATA_WIDTH-1:0]       r_new_data;
    logic signed [PRI_WIDTH-1:0] r_new_pri;

    logic                        r_strobe;
    logic [DATA_WIDTH-1:0]       r_res_data, n_res_data;
    logic                        r_res_valid, n_res_valid;
    logic [1:0]                  r_status, n_status;

    t_cell_ctl                   w_ctl;
    logic                        w_accept;
    logic                        w_empty;
    logic                        w_full;
    logic [CW-1:0]               w_top_idx;
    logic [DATA_WIDTH-1:0]       w_top_data;

    logic                        w_lt   [CAPACITY];
    logic signed [PRI_WIDTH-1:0] w_pri  [CAPACITY];
    logic [DATA_WIDTH-1:0]       w_data [CAPACITY];

    assign busy     = r_state != S_IDLE;
    assign w_accept = start && !busy;
    assign w_empty  = r_count == '0;
    assign w_full   = r_count == CW'(CAPACITY);
    assign w_top_idx = r_count - CW'(1);

    // ------------------------------------------------------------------
    // Sequencer: latch the command, wait out the readout, then execute
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func     <= i_func;
            r_new_data <= i_new_data;
            r_new_pri  <= i_new_priority;
        end
    end

    // ------------------------------------------------------------------
    // Chain command and result formation in the execute cycle
    // ------------------------------------------------------------------
    always_comb begin
        w_ctl.op    = CELL_HOLD;
        w_ctl.pri   = r_new_pri;
        n_count     = r_count;
        n_res_data  = '0;
        n_res_valid = 1'b0;
        n_status    = ST_OK;
        if (r_state == S_EXEC) begin
            case (r_func)
                FN_INSERT: begin
                    if (w_full) begin
                        // drop the entry and flag it
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.op = CELL_INSERT;
                        n_count  = r_count + CW'(1);
                    end
                end
                FN_POP_HIGH, FN_PEEK: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_res_data  = w_top_data;
                        n_res_valid = 1'b1;
                        if (r_func == FN_POP_HIGH) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
                FN_POP_LOW: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        // lowest sits in cell 0; advance everything down
                        w_ctl.op    = CELL_SHIFT;
                        n_res_data  = w_data[0];
                        n_res_valid = 1'b1;
                        n_count     = r_count - CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= r_state == S_EXEC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_res_data  <= n_res_data;
            r_res_valid <= n_res_valid;
            r_status    <= n_status;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: cell 0 holds the lowest priority
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                        w_prev_lt;
        logic signed [PRI_WIDTH-1:0] w_prev_pri;
        logic [DATA_WIDTH-1:0]       w_prev_data;
        logic signed [PRI_WIDTH-1:0] w_next_pri;
        logic [DATA_WIDTH-1:0]       w_next_data;

        if (i == 0) begin : g_first
            assign w_prev_lt   = 1'b1;
            assign w_prev_pri  = w_pri[i];
            assign w_prev_data = w_data[i];
        end else begin : g_mid
            assign w_prev_lt   = w_lt[i-1];
            assign w_prev_pri  = w_pri[i-1];
            assign w_prev_data = w_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_next_pri  = w_pri[i];
            assign w_next_data = w_data[i];
        end else begin : g_inner
            assign w_next_pri  = w_pri[i+1];
            assign w_next_data = w_data[i+1];
        end

        spq_cell #(
            .IDX        (i),
            .DATA_WIDTH (DATA_WIDTH),
            .CW         (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_new_data  (r_new_data),
            .i_count     (r_count),
            .i_prev_lt   (w_prev_lt),
            .i_prev_pri  (w_prev_pri),
            .i_prev_data (w_prev_data),
            .i_next_pri  (w_next_pri),
            .i_next_data (w_next_data),
            .o_lt        (w_lt[i]),
            .o_pri       (w_pri[i]),
            .o_data      (w_data[i])
        );
    end

    // Read the top cell (index count-1) through the registered select
    spq_tree #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .IW         (IW)
    ) u_tree (
        .i_clk  (i_clk),
        .i_data (w_data),
        .i_idx  (w_top_idx[IW-1:0]),
        .o_data (w_top_data)
    );

    assign o_strobe       = r_strobe;
    assign o_result_data  = r_res_data;
    assign o_result_valid = r_res_valid;
    assign o_status       = r_status;
    assign o_count        = r_count;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == S_EXEC)
        else $error("result beat without an execute cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result_valid |-> o_status == ST_OK)
        else $error("valid result with error status");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status == ST_FULL |-> o_count == CW'(CAPACITY))
        else $error("full status while not full");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after start beat");

endmodule
